/* rtl/crc_checked_frame_parser_assert.svh */
// assertion macros for the frame parser, sampled on clk, off during reset
`ifndef CRC_CHECKED_FRAME_PARSER_ASSERT_SVH
`define CRC_CHECKED_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define CCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ccfp_pkg.sv */
package ccfp_pkg;

  // payload geometry
  localparam int PAYLOAD_BYTES = 32;
  localparam int PB_AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // sequence gaps at or above this are ignored
  localparam logic [15:0] GAP_LIMIT = 16'd1000;

  // configuration register indexes
  localparam logic [2:0] CFG_SYNC_FIRST      = 3'd0;
  localparam logic [2:0] CFG_SYNC_SECOND     = 3'd1;
  localparam logic [2:0] CFG_FORMAT_VERSION  = 3'd2;
  localparam logic [2:0] CFG_MAX_SKIP_LENGTH = 3'd3;
  localparam logic [2:0] CFG_SEQ_OFFSET      = 3'd4;

  // result status codes
  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_OK         = 3'd1,
    ST_FORMAT_ERR = 3'd2,
    ST_LENGTH_ERR = 3'd3,
    ST_CRC_ERR    = 3'd4
  } status_t;

  // frame parsing phase
  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_FMT   = 3'd2,
    PH_LEN   = 3'd3,
    PH_SKIP  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CRCLO = 3'd6,
    PH_CRCHI = 3'd7
  } ph_t;

  // sequencer state around the payload memory
  typedef enum logic [2:0] {
    C_BYTE   = 3'd0,
    C_SEQ_LO = 3'd1,
    C_SEQ_HI = 3'd2,
    C_GAP    = 3'd3,
    C_EMIT   = 3'd4
  } ctl_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ccfp_ram.sv */
module ccfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/crc_checked_frame_parser.sv */
// Sync-header frame parser with CRC-16/CCITT-FALSE check. Bytes are taken one per
// cycle into a one-byte holding stage and parsed there, so the input keeps running at
// one byte per cycle as long as results are taken; while a result waits on the output,
// one more byte can still enter the holding stage and the input stalls after it. Every
// byte gives one result, except the trailer byte that completes a good frame: the
// payload sits in a PAYLOAD_BYTES x 8 memory, and after the trailer the block reads
// the sequence bytes, updates the gap and counters, then reads the payload out of the
// memory's single read port, one result per cycle while the output does not stall.
// Parsing is held up for all of that; the holding stage takes one byte in that time
// and the input is stalled after it.
// The payload memory needs no clearing pass after reset.
`include "crc_checked_frame_parser_assert.svh"

module crc_checked_frame_parser
  import ccfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  output logic [31:0] out_packets_seen,
  output logic [31:0] out_resync_count,
  output logic [31:0] out_format_error_count,
  output logic [31:0] out_crc_error_count,
  output logic [31:0] out_dropped_count
);

  localparam logic [PB_AW-1:0] LAST_IDX = PB_AW'(PAYLOAD_BYTES - 1);

  // configuration
  logic [7:0] sync_first_r, sync_second_r, format_version_r, max_skip_length_r;
  logic [5:0] seq_offset_r;

  // holding stage
  logic       in_hold_valid_r, in_hold_valid_nxt;
  logic [7:0] in_hold_r, in_hold_nxt;

  // parser state
  ph_t         phase_r, phase_nxt;
  ctl_t        ctl_r, ctl_nxt;
  logic [7:0]  format_byte_r, format_byte_nxt;
  logic [7:0]  declared_length_r, declared_length_nxt;
  logic [8:0]  byte_counter_r, byte_counter_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_low_byte_r, crc_low_byte_nxt;
  logic        have_sequence_r, have_sequence_nxt;
  logic [15:0] last_sequence_r, last_sequence_nxt;
  logic [7:0]  seq_lo_r, seq_lo_nxt;
  logic [PB_AW-1:0] emit_idx_r, emit_idx_nxt;

  // counters
  logic [31:0] packet_counter_r, packet_counter_nxt;
  logic [31:0] resync_counter_r, resync_counter_nxt;
  logic [31:0] format_error_counter_r, format_error_counter_nxt;
  logic [31:0] crc_error_counter_r, crc_error_counter_nxt;
  logic [31:0] dropped_counter_r, dropped_counter_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [7:0] out_payload_byte_r, out_payload_byte_nxt;
  logic [5:0] out_byte_index_r, out_byte_index_nxt;
  logic       out_last_r, out_last_nxt;

  // payload memory ports
  logic             ram_we, ram_re;
  logic [PB_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // misc combinational
  logic        out_free, proc;
  logic [6:0]  seq_pos_lo, seq_pos_hi;
  logic        seq_lo_in, seq_hi_in;
  logic [15:0] seq_val, gap;
  logic [15:0] crc_step;
  logic [8:0]  cnt_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = (ctl_r == C_BYTE) && in_hold_valid_r && out_free;
  assign in_stall = in_hold_valid_r && !proc;

  assign seq_pos_lo = {1'b0, seq_offset_r};
  assign seq_pos_hi = seq_pos_lo + 7'd1;
  assign seq_lo_in  = seq_pos_lo < 7'(PAYLOAD_BYTES);
  assign seq_hi_in  = seq_pos_hi < 7'(PAYLOAD_BYTES);
  assign seq_val    = {(seq_hi_in ? ram_rdata : 8'h00), seq_lo_r};
  assign gap        = seq_val - (last_sequence_r + 16'd1);
  assign crc_step   = crc_byte((phase_r == PH_FMT) ? CRC_INIT : running_crc_r, in_hold_r);
  assign cnt_inc    = byte_counter_r + 9'd1;

  ccfp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r      <= 8'hAA;
      sync_second_r     <= 8'h55;
      format_version_r  <= 8'h01;
      max_skip_length_r <= 8'hFF;
      seq_offset_r      <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:      sync_first_r      <= cfg_data;
        CFG_SYNC_SECOND:     sync_second_r     <= cfg_data;
        CFG_FORMAT_VERSION:  format_version_r  <= cfg_data;
        CFG_MAX_SKIP_LENGTH: max_skip_length_r <= cfg_data;
        CFG_SEQ_OFFSET:      seq_offset_r      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // parser, sequencer and output next state
  always_comb begin
    in_hold_valid_nxt        = in_hold_valid_r;
    in_hold_nxt              = in_hold_r;
    phase_nxt                = phase_r;
    ctl_nxt                  = ctl_r;
    format_byte_nxt          = format_byte_r;
    declared_length_nxt      = declared_length_r;
    byte_counter_nxt         = byte_counter_r;
    running_crc_nxt          = running_crc_r;
    crc_low_byte_nxt         = crc_low_byte_r;
    have_sequence_nxt        = have_sequence_r;
    last_sequence_nxt        = last_sequence_r;
    seq_lo_nxt               = seq_lo_r;
    emit_idx_nxt             = emit_idx_r;
    packet_counter_nxt       = packet_counter_r;
    resync_counter_nxt       = resync_counter_r;
    format_error_counter_nxt = format_error_counter_r;
    crc_error_counter_nxt    = crc_error_counter_r;
    dropped_counter_nxt      = dropped_counter_r;
    out_valid_nxt            = out_free ? 1'b0 : out_valid_r;
    out_status_nxt           = out_status_r;
    out_payload_byte_nxt     = out_payload_byte_r;
    out_byte_index_nxt       = out_byte_index_r;
    out_last_nxt             = out_last_r;
    ram_we                   = 1'b0;
    ram_waddr                = byte_counter_r[PB_AW-1:0];
    ram_wdata                = in_hold_r;
    ram_re                   = 1'b0;
    ram_raddr                = seq_pos_lo[PB_AW-1:0];

    // input transaction into the holding stage
    if (in_valid && !in_stall) begin
      in_hold_valid_nxt = 1'b1;
      in_hold_nxt       = in_byte;
    end else if (proc) begin
      in_hold_valid_nxt = 1'b0;
    end

    case (ctl_r)
      C_BYTE: begin
        if (proc) begin
          // single result unless the trailer completes a good frame
          out_valid_nxt        = 1'b1;
          out_status_nxt       = ST_INCOMPLETE;
          out_payload_byte_nxt = 8'h00;
          out_byte_index_nxt   = 6'd0;
          out_last_nxt         = 1'b1;
          case (phase_r)
            PH_HDR1: begin
              if (in_hold_r == sync_first_r) phase_nxt = PH_HDR2;
            end
            PH_HDR2: begin
              if (in_hold_r == sync_second_r) begin
                phase_nxt = PH_FMT;
              end else if (in_hold_r != sync_first_r) begin
                resync_counter_nxt = resync_counter_r + 32'd1;
                phase_nxt          = PH_HDR1;
              end
            end
            PH_FMT: begin
              format_byte_nxt = in_hold_r;
              running_crc_nxt = crc_step;
              phase_nxt       = PH_LEN;
            end
            PH_LEN: begin
              declared_length_nxt = in_hold_r;
              byte_counter_nxt    = 9'd0;
              running_crc_nxt     = crc_step;
              if (format_byte_r != format_version_r) begin
                format_error_counter_nxt = format_error_counter_r + 32'd1;
                phase_nxt      = (in_hold_r != 8'h00) ? PH_SKIP : PH_HDR1;
                out_status_nxt = ST_FORMAT_ERR;
              end else if (in_hold_r != 8'(PAYLOAD_BYTES)) begin
                phase_nxt = ((in_hold_r != 8'h00) && (in_hold_r <= max_skip_length_r)) ?
                            PH_SKIP : PH_HDR1;
                out_status_nxt = ST_LENGTH_ERR;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
            PH_SKIP: begin
              // drain length plus both crc bytes
              byte_counter_nxt = cnt_inc;
              if (cnt_inc >= ({1'b0, declared_length_r} + 9'd2)) phase_nxt = PH_HDR1;
            end
            PH_DATA: begin
              ram_we           = byte_counter_r < 9'(PAYLOAD_BYTES);
              running_crc_nxt  = crc_step;
              byte_counter_nxt = cnt_inc;
              if (cnt_inc >= {1'b0, declared_length_r}) phase_nxt = PH_CRCLO;
            end
            PH_CRCLO: begin
              crc_low_byte_nxt = in_hold_r;
              phase_nxt        = PH_CRCHI;
            end
            PH_CRCHI: begin
              phase_nxt = PH_HDR1;
              if ({in_hold_r, crc_low_byte_r} == running_crc_r) begin
                out_valid_nxt = 1'b0;
                ctl_nxt       = C_SEQ_LO;
              end else begin
                crc_error_counter_nxt = crc_error_counter_r + 32'd1;
                out_status_nxt        = ST_CRC_ERR;
              end
            end
            default: ;
          endcase
        end
      end
      C_SEQ_LO: begin
        ram_re    = 1'b1;
        ram_raddr = seq_pos_lo[PB_AW-1:0];
        ctl_nxt   = C_SEQ_HI;
      end
      C_SEQ_HI: begin
        seq_lo_nxt = seq_lo_in ? ram_rdata : 8'h00;
        ram_re     = 1'b1;
        ram_raddr  = seq_pos_hi[PB_AW-1:0];
        ctl_nxt    = C_GAP;
      end
      C_GAP: begin
        // counters move only while no result waits on them
        if (out_free) begin
          packet_counter_nxt = packet_counter_r + 32'd1;
          if (have_sequence_r && (gap != 16'd0) && (gap < GAP_LIMIT)) begin
            dropped_counter_nxt = dropped_counter_r + {16'h0000, gap};
          end
          have_sequence_nxt = 1'b1;
          last_sequence_nxt = seq_val;
          ram_re            = 1'b1;
          ram_raddr         = '0;
          emit_idx_nxt      = '0;
          ctl_nxt           = C_EMIT;
        end
      end
      C_EMIT: begin
        // one payload byte per cycle from the read port, while the output does not stall
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = ST_OK;
          out_payload_byte_nxt = ram_rdata;
          out_byte_index_nxt   = 6'(emit_idx_r);
          out_last_nxt         = emit_idx_r == LAST_IDX;
          if (emit_idx_r == LAST_IDX) begin
            ctl_nxt = C_BYTE;
          end else begin
            emit_idx_nxt = emit_idx_r + PB_AW'(1);
            ram_re       = 1'b1;
            ram_raddr    = emit_idx_r + PB_AW'(1);
          end
        end
      end
      default: ctl_nxt = C_BYTE;
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hold_valid_r        <= 1'b0;
      phase_r                <= PH_HDR1;
      ctl_r                  <= C_BYTE;
      format_byte_r          <= 8'h00;
      declared_length_r      <= 8'h00;
      byte_counter_r         <= 9'd0;
      running_crc_r          <= CRC_INIT;
      crc_low_byte_r         <= 8'h00;
      have_sequence_r        <= 1'b0;
      last_sequence_r        <= 16'h0000;
      emit_idx_r             <= '0;
      packet_counter_r       <= 32'd0;
      resync_counter_r       <= 32'd0;
      format_error_counter_r <= 32'd0;
      crc_error_counter_r    <= 32'd0;
      dropped_counter_r      <= 32'd0;
      out_valid_r            <= 1'b0;
    end else begin
      in_hold_valid_r        <= in_hold_valid_nxt;
      phase_r                <= phase_nxt;
      ctl_r                  <= ctl_nxt;
      format_byte_r          <= format_byte_nxt;
      declared_length_r      <= declared_length_nxt;
      byte_counter_r         <= byte_counter_nxt;
      running_crc_r          <= running_crc_nxt;
      crc_low_byte_r         <= crc_low_byte_nxt;
      have_sequence_r        <= have_sequence_nxt;
      last_sequence_r        <= last_sequence_nxt;
      emit_idx_r             <= emit_idx_nxt;
      packet_counter_r       <= packet_counter_nxt;
      resync_counter_r       <= resync_counter_nxt;
      format_error_counter_r <= format_error_counter_nxt;
      crc_error_counter_r    <= crc_error_counter_nxt;
      dropped_counter_r      <= dropped_counter_nxt;
      out_valid_r            <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_hold_r          <= in_hold_nxt;
    seq_lo_r           <= seq_lo_nxt;
    out_status_r       <= out_status_nxt;
    out_payload_byte_r <= out_payload_byte_nxt;
    out_byte_index_r   <= out_byte_index_nxt;
    out_last_r         <= out_last_nxt;
  end

  // outputs
  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_payload_byte       = out_payload_byte_r;
  assign out_byte_index         = out_byte_index_r;
  assign out_last               = out_last_r;
  assign out_packets_seen       = packet_counter_r;
  assign out_resync_count       = resync_counter_r;
  assign out_format_error_count = format_error_counter_r;
  assign out_crc_error_count    = crc_error_counter_r;
  assign out_dropped_count      = dropped_counter_r;

  // checks
  `CCFP_ASSERT_NEXT(a_counters_hold, out_valid_r && out_stall, $stable(packet_counter_r) && $stable(crc_error_counter_r) && $stable(dropped_counter_r), "counters moved under a waiting transaction")
  `CCFP_ASSERT_NOW(a_err_no_payload, out_valid_r && (out_status_r != ST_OK), out_last_r && (out_payload_byte_r == 8'h00) && (out_byte_index_r == 6'd0), "non-frame transaction carries payload")
  `CCFP_ASSERT_NOW(a_last_at_end, out_valid_r && (out_status_r == ST_OK) && out_last_r, out_byte_index_r == 6'(PAYLOAD_BYTES - 1), "frame ended at wrong index")
  `CCFP_ASSERT_NOW(a_no_write_in_readout, ctl_r != C_BYTE, !ram_we && !proc, "payload memory written during readout")

endmodule

/* bench/crc_checked_frame_parser_tb.sv */
`timescale 1ns / 100ps

module crc_checked_frame_parser_tb;
  import ccfp_pkg::*;

  localparam int RANDOM_BYTES = 40;
  localparam int MAX_WAIT = 18;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [7:0] FRAME_LEN_BYTE = 8'(PAYLOAD_BYTES);

  // one parser result as it appears on the output ports
  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [31:0] packets;
    logic [31:0] resyncs;
    logic [31:0] fmt_errs;
    logic [31:0] crc_errors;
    logic [31:0] dropped;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SYNC_FIRST;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_payload_byte;
  logic [5:0]  out_byte_index;
  logic        out_last;
  logic [31:0] out_packets_seen;
  logic [31:0] out_resync_count;
  logic [31:0] out_format_error_count;
  logic [31:0] out_crc_error_count;
  logic [31:0] out_dropped_count;

  crc_checked_frame_parser dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_byte                (in_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_payload_byte       (out_payload_byte),
    .out_byte_index         (out_byte_index),
    .out_last               (out_last),
    .out_packets_seen       (out_packets_seen),
    .out_resync_count       (out_resync_count),
    .out_format_error_count (out_format_error_count),
    .out_crc_error_count    (out_crc_error_count),
    .out_dropped_count      (out_dropped_count)
  );

  always #4 clk = ~clk;

  // register copies
  logic [7:0] reg_sync_first;
  logic [7:0] reg_sync_second;
  logic [7:0] reg_format;
  logic [7:0] reg_skip_max;
  logic [5:0] reg_seq_offset;

  // parser state copy
  ph_t         parse_phase;
  logic [7:0]  fmt_seen;
  logic [7:0]  len_seen;
  logic [8:0]  pos_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_seen;
  logic [7:0]  payload_copy [PAYLOAD_BYTES];
  logic        seq_known;
  logic [15:0] prev_seq;
  logic [31:0] cnt_packets;
  logic [31:0] cnt_resync;
  logic [31:0] cnt_format_err;
  logic [31:0] cnt_crc_err;
  logic [31:0] cnt_dropped;

  parse_result_t results_due [$];
  parse_result_t due;

  int          n_mismatch = 0;
  int          results_checked = 0;
  int          bytes_sent = 0;
  int          settings_applied = 0;
  int          calm_left [2] = '{0, 0};
  int          stall_left = 0;
  logic [15:0] seq_next = 16'h0000;

  // crc-16/ccitt-false, one bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] payload_at(input int pos);
    return (pos < PAYLOAD_BYTES) ? payload_copy[pos[PB_AW-1:0]] : 8'h00;
  endfunction

  // wait cycles per transaction, with runs of back-to-back traffic
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == reg_sync_first);
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    n_mismatch++;
  endtask

  task automatic push_result(input status_t st, input logic [7:0] pb, input logic [5:0] idx,
                             input logic lst);
    parse_result_t r;
    r.status       = st;
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.last         = lst;
    r.packets      = cnt_packets;
    r.resyncs      = cnt_resync;
    r.fmt_errs     = cnt_format_err;
    r.crc_errors   = cnt_crc_err;
    r.dropped      = cnt_dropped;
    results_due.push_back(r);
  endtask

  // advance the parser copy by one accepted byte and queue what it yields
  task automatic advance_parser(input logic [7:0] b);
    status_t     st;
    logic [15:0] seq;
    logic [15:0] gap;
    logic        frame_done;
    st = ST_INCOMPLETE;
    frame_done = 1'b0;
    case (parse_phase)
      PH_HDR1: begin
        if (b == reg_sync_first) parse_phase = PH_HDR2;
      end
      PH_HDR2: begin
        // second sync byte is tested first, so equal sync bytes still frame
        if (b == reg_sync_second) begin
          parse_phase = PH_FMT;
        end else if (b != reg_sync_first) begin
          cnt_resync++;
          parse_phase = PH_HDR1;
        end
      end
      PH_FMT: begin
        fmt_seen = b;
        crc_acc = crc16_update(CRC_INIT, b);
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        len_seen = b;
        pos_count = 9'd0;
        crc_acc = crc16_update(crc_acc, b);
        if (fmt_seen != reg_format) begin
          cnt_format_err++;
          parse_phase = (b != 8'd0) ? PH_SKIP : PH_HDR1;
          st = ST_FORMAT_ERR;
        end else if (b != FRAME_LEN_BYTE) begin
          parse_phase = (b != 8'd0 && b <= reg_skip_max) ? PH_SKIP : PH_HDR1;
          st = ST_LENGTH_ERR;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_SKIP: begin
        // the skip drains the claimed length plus both crc bytes
        pos_count = pos_count + 9'd1;
        if (pos_count >= {1'b0, len_seen} + 9'd2) parse_phase = PH_HDR1;
      end
      PH_DATA: begin
        if (pos_count < PAYLOAD_BYTES) payload_copy[pos_count[PB_AW-1:0]] = b;
        crc_acc = crc16_update(crc_acc, b);
        pos_count = pos_count + 9'd1;
        if (pos_count >= {1'b0, len_seen}) parse_phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        crc_lo_seen = b;
        parse_phase = PH_CRCHI;
      end
      PH_CRCHI: begin
        parse_phase = PH_HDR1;
        if ({b, crc_lo_seen} == crc_acc) begin
          // sequence bytes past the payload read as zero
          seq = {payload_at(int'(reg_seq_offset) + 1), payload_at(int'(reg_seq_offset))};
          cnt_packets++;
          if (seq_known) begin
            gap = seq - (prev_seq + 16'd1);
            if (gap != 16'd0 && gap < GAP_LIMIT) cnt_dropped = cnt_dropped + 32'(gap);
          end
          seq_known = 1'b1;
          prev_seq = seq;
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            push_result(ST_OK, payload_copy[PB_AW'(i)], 6'(i), i == PAYLOAD_BYTES - 1);
          end
          frame_done = 1'b1;
        end else begin
          cnt_crc_err++;
          st = ST_CRC_ERR;
        end
      end
      default: ;
    endcase
    if (!frame_done) push_result(st, 8'h00, 6'd0, 1'b1);
  endtask

  // one input transaction, preceded by a random idle stretch
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    advance_parser(b);
    bytes_sent++;
  endtask

  // wait until every queued result is out and the block is quiet
  task automatic wait_results_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SYNC_FIRST:      reg_sync_first = val;
      CFG_SYNC_SECOND:     reg_sync_second = val;
      CFG_FORMAT_VERSION:  reg_format = val;
      CFG_MAX_SKIP_LENGTH: reg_skip_max = val;
      CFG_SEQ_OFFSET:      reg_seq_offset = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] sync_a, input logic [7:0] sync_b,
                               input logic [7:0] fmt, input logic [7:0] skip_max,
                               input logic [5:0] seq_off);
    wait_results_idle();
    write_register(CFG_SYNC_FIRST, sync_a);
    write_register(CFG_SYNC_SECOND, sync_b);
    write_register(CFG_FORMAT_VERSION, fmt);
    write_register(CFG_MAX_SKIP_LENGTH, skip_max);
    write_register(CFG_SEQ_OFFSET, {2'b00, seq_off});
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic set_random_registers();
    logic [7:0] sync_a;
    logic [7:0] sync_b;
    logic [7:0] skip_max;
    logic [5:0] seq_off;
    sync_a = 8'($urandom);
    sync_b = ($urandom_range(0, 3) == 0) ? sync_a : 8'($urandom);
    skip_max = $urandom_range(0, 1) ? 8'($urandom_range(1, 40)) : 8'($urandom_range(1, 255));
    seq_off = $urandom_range(0, 2) ? 6'($urandom_range(0, 30)) : 6'($urandom_range(0, 62));
    set_registers(sync_a, sync_b, 8'($urandom), skip_max, seq_off);
  endtask

  // bring the parser back to the hunt, then send both sync bytes
  task automatic send_header();
    while (parse_phase != PH_HDR1) send_byte(stray_byte());
    send_byte(reg_sync_first);
    send_byte(reg_sync_second);
  endtask

  // fill: 0 random, 1 all zero, 2 all ones; spoil: 0 none, 1 trailer bit, 2 payload bit
  task automatic send_good_frame(input logic [15:0] seq, input int spoil, input int fill);
    logic [7:0]  body [PAYLOAD_BYTES];
    logic [15:0] crc;
    int          pos;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      body[PB_AW'(i)] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
    end
    pos = int'(reg_seq_offset);
    if (pos < PAYLOAD_BYTES) body[PB_AW'(pos)] = seq[7:0];
    if (pos + 1 < PAYLOAD_BYTES) body[PB_AW'(pos + 1)] = seq[15:8];
    crc = crc16_update(CRC_INIT, reg_format);
    crc = crc16_update(crc, FRAME_LEN_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) crc = crc16_update(crc, body[PB_AW'(i)]);
    if (spoil == 1) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    if (spoil == 2) begin
      pos = $urandom_range(0, PAYLOAD_BYTES - 1);
      body[PB_AW'(pos)] = body[PB_AW'(pos)] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_header();
    send_byte(reg_format);
    send_byte(FRAME_LEN_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(body[PB_AW'(i)]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // header with a bad format or bad length, plus whatever the skip drains
  task automatic send_rejected_frame(input logic [7:0] fmt, input logic [7:0] len);
    int skip;
    if (fmt != reg_format) begin
      skip = (len != 8'd0) ? len + 2 : 0;
    end else begin
      skip = (len != 8'd0 && len <= reg_skip_max) ? len + 2 : 0;
    end
    send_header();
    send_byte(fmt);
    send_byte(len);
    repeat (skip) send_byte(8'($urandom));
  endtask

  // ---- tests ----

  // hunt: extreme bytes, held first sync byte, broken headers
  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(reg_sync_first);
    send_byte(reg_sync_first);
    send_byte(reg_sync_first);
    send_byte(8'h13);
    send_byte(reg_sync_first);
    send_byte(8'hFF);
  endtask

  // unknown format with zero length, then with a short skip
  task automatic test_bad_format();
    send_rejected_frame(reg_format ^ 8'h01, 8'd0);
    send_rejected_frame(reg_format ^ 8'hFE, 8'd1);
  endtask

  // good format, wrong length: zero resyncs at once, short length is skipped
  task automatic test_length_errors();
    send_rejected_frame(reg_format, 8'd0);
    send_rejected_frame(reg_format, 8'd1);
  endtask

  // all-ones payload, sequence just below the wrap
  task automatic test_good_frames();
    seq_next = 16'hFFFE;
    send_good_frame(seq_next, 0, 2);
    seq_next++;
  endtask

  // trailer bit flipped; payload bit flips come with the random traffic
  task automatic test_crc_errors();
    send_good_frame(seq_next, 1, 0);
  endtask

  // wrap, largest counted gap, first ignored gap, in order
  task automatic test_sequence_gaps();
    logic [15:0] seqs [3];
    seqs = '{16'h0000, 16'd1000, 16'd2001};
    for (int f = 0; f < 3; f++) send_good_frame(seqs[2'(f)], 0, (f == 0) ? 1 : 0);
    seq_next = 16'd2002;
  endtask

  task automatic test_register_extremes();
    // extreme sync bytes, tightest skip limit, sequence straddling the payload end
    set_registers(8'h00, 8'hFF, 8'hFF, 8'd1, 6'd31);
    send_good_frame(16'h1234, 0, 0);
    send_rejected_frame(8'hFF, 8'd2);
    send_rejected_frame(8'hFF, 8'd1);
    send_rejected_frame(8'h00, 8'd0);
    // equal sync bytes, widest skip, sequence wholly past the payload
    set_registers(8'hFF, 8'hFF, 8'h00, 8'd255, 6'd62);
    send_good_frame(16'h0000, 0, 0);
    send_rejected_frame(8'h00, 8'd33);
    // mid values, length just above the skip limit
    set_registers(8'h5A, 8'hA5, 8'h80, 8'd127, 6'd30);
    send_rejected_frame(8'h80, 8'd128);
  endtask

  // well-formed frames with random content, along with broken ones and noise
  task automatic test_random_traffic();
    int  start;
    bit  reconfigured;
    logic [7:0] len;
    start = bytes_sent;
    reconfigured = 1'b0;
    set_random_registers();
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (!reconfigured && bytes_sent - start >= RANDOM_BYTES / 2) begin
        set_random_registers();
        reconfigured = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 5) == 0) seq_next = seq_next + 16'($urandom_range(1, 1200));
          if ($urandom_range(0, 7) == 0) seq_next = seq_next - 16'd1;
          send_good_frame(seq_next, 0, 0);
          seq_next++;
        end
        4: send_good_frame(seq_next, $urandom_range(1, 2), 0);
        5: send_rejected_frame(reg_format ^ 8'($urandom_range(1, 255)),
                               8'($urandom_range(0, 8)));
        6: begin
          len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
          if (len == FRAME_LEN_BYTE) len = FRAME_LEN_BYTE + 8'd1;
          send_rejected_frame(reg_format, len);
        end
        7: repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        8: begin
          while (parse_phase != PH_HDR1) send_byte(stray_byte());
          send_byte(reg_sync_first);
          send_byte(8'($urandom));
        end
        default: begin
          // frame cut short; later bytes complete it, normally as a crc failure
          send_header();
          send_byte(reg_format);
          send_byte(FRAME_LEN_BYTE);
          repeat ($urandom_range(0, 20)) send_byte(8'($urandom));
        end
      endcase
    end
  endtask

  // ---- result checking ----

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_checked, name, got, want));
    end
  endtask

  // every accepted result transaction against the oldest one queued
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with status %0d arrived with none pending",
                                  results_checked, out_status));
      end else begin
        due = results_due.pop_front();
        check_field("status", out_status, due.status);
        check_field("payload_byte", out_payload_byte, due.payload_byte);
        check_field("byte_index", out_byte_index, due.byte_index);
        check_field("last", out_last, due.last);
        check_field("packets_seen", out_packets_seen, due.packets);
        check_field("resync_count", out_resync_count, due.resyncs);
        check_field("format_error_count", out_format_error_count, due.fmt_errs);
        check_field("crc_error_count", out_crc_error_count, due.crc_errors);
        check_field("dropped_count", out_dropped_count, due.dropped);
      end
      results_checked++;
      stall_left = draw_wait(1);
    end
  end

  // receiver stall after each result transaction
  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // ---- run ----

  initial begin
    reg_sync_first = 8'hAA;
    reg_sync_second = 8'h55;
    reg_format = 8'h01;
    reg_skip_max = 8'hFF;
    reg_seq_offset = 6'd0;
    parse_phase = PH_HDR1;
    fmt_seen = 8'h00;
    len_seen = 8'h00;
    pos_count = 9'd0;
    crc_acc = CRC_INIT;
    crc_lo_seen = 8'h00;
    seq_known = 1'b0;
    prev_seq = 16'h0000;
    cnt_packets = 32'd0;
    cnt_resync = 32'd0;
    cnt_format_err = 32'd0;
    cnt_crc_err = 32'd0;
    cnt_dropped = 32'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_registers(8'hAA, 8'h55, 8'h01, 8'hFF, 6'd0);
    test_header_hunt();
    test_bad_format();
    test_length_errors();
    test_good_frames();
    test_crc_errors();
    test_sequence_gaps();
    test_register_extremes();
    test_random_traffic();

    wait_results_idle();
    repeat (PAYLOAD_BYTES + 8) @(posedge clk);
    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    end

    $display("%0d bytes sent under %0d register settings, %0d results checked, %0d mismatches",
             bytes_sent, settings_applied, results_checked, n_mismatch);
    $display("frames: %0d good, %0d crc failures, %0d format errors, %0d resyncs, %0d dropped",
             cnt_packets, cnt_crc_err, cnt_format_err, cnt_resync, cnt_dropped);
    if (n_mismatch == 0) begin
      $display("crc_checked_frame_parser regression: pass");
    end else begin
      $display("crc_checked_frame_parser regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", results_due.size());
    $display("crc_checked_frame_parser regression: fail");
    $finish;
  end

endmodule
